// File: design/swrl_pkg.sv
// package for the sliding window rate limiter
// holds payload structs, kind codes and default sizes; no dependencies
package swrl_pkg;

    localparam int KEYS_DEF       = 16;
    localparam int RING_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF  = 32;
    localparam logic [15:0] WINDOW_RESET = 16'd60;

    localparam logic [2:0] K_TICK   = 3'd0;
    localparam logic [2:0] K_REQ    = 3'd1;
    localparam logic [2:0] K_PEEK   = 3'd2;
    localparam logic [2:0] K_REC    = 3'd3;
    localparam logic [2:0] K_CLRKEY = 3'd4;
    localparam logic [2:0] K_CLRALL = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] key_index;
        logic [6:0] limit;
    } t_in_item;

    typedef struct packed {
        logic        allowed;
        logic [6:0]  count;
        logic [6:0]  remaining;
        logic [15:0] wait_ticks;
        logic        overflow;
    } t_out_item;

endpackage

// File: design/sliding_window_rate_limiter.sv
// top level of the sliding window rate limiter
// depends on swrl_pkg, swrl_front, swrl_back
//
// usage
// - input channel i_valid / o_ready carries one item (kind, key, limit)
// - output channel o_valid / i_ready returns one result item per input item
// - i_cfg_we with i_cfg_data writes the window length; users must write
//   it only while idle, as the block itself does not enforce it
// - items pass idle, read, wait, check and output; each popped expired stamp
//   repeats read, wait and check, since the stamp memory's read is registered
// - a two item queue in front keeps accepting while a result waits
// - a stalled receiver holds the result; the back end waits, the queue fills
// - reset clears time, ring heads and counts at once; stamps need no
//   clearing as only recorded entries are read
// - window resets to 60 ticks
module sliding_window_rate_limiter
    import swrl_pkg::*;
#(
    parameter int KEYS       = KEYS_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_window;
    logic        q_valid, q_pop;
    t_in_item    q_item;

    // window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_data;
        end
    end

    swrl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    swrl_back #(.KEYS(KEYS), .RING_DEPTH(RING_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_window(r_window),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );
endmodule

// File: design/swrl_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/swrl_front.sv
// front end: accepts items into a two entry queue
// depends on swrl_pkg
module swrl_front
    import swrl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_q_valid,
    input  logic     i_q_pop,
    output t_in_item o_q_item
);
    t_in_item r_buf [2];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_buf[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: design/swrl_back.sv
// back end: expiry sequencer, decision and ring update
// depends on swrl_pkg and swrl_ram
module swrl_back
    import swrl_pkg::*;
#(
    parameter int KEYS       = KEYS_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_window,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_in_item    i_q_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);
    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int HW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int AW = $clog2(KEYS * RING_DEPTH);
    localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]           r_state;
    logic [TIME_BITS-1:0] r_time;
    logic [HW-1:0]        r_head [KEYS];
    logic [CW-1:0]        r_cnt  [KEYS];
    t_in_item             r_it;
    logic [KW-1:0]        r_key;
    t_out_item            r_out;

    logic [TIME_BITS-1:0] rdata, age;
    logic [AW-1:0]        raddr, waddr;
    logic                 we;
    logic [HW-1:0]        hd, wpos, hd_next;
    logic [CW:0]          wsum;
    logic [CW-1:0]        ct;
    logic                 live, allowed, push;
    logic [16:0]          diff;

    // key modulo the key count, as a small constant table
    function automatic logic [KW-1:0] key_slot(input logic [3:0] k);
        logic [KW-1:0] s;
        s = '0;
        for (int j = 0; j < 16; j++) begin
            if (k == 4'(j)) s = KW'(j % KEYS);
        end
        return s;
    endfunction

    assign hd = r_head[r_key];
    assign ct = r_cnt[r_key];
    assign age = r_time - rdata;
    assign live = age <= TIME_BITS'(i_window);
    assign allowed = {{(8 > CW ? 8 - CW : 0){1'b0}}, ct} < 8'(r_it.limit);
    assign diff = {1'b0, i_window} - 17'(age);
    assign push = (r_it.kind == K_REC) || (r_it.kind == K_REQ && allowed);
    assign wsum = (CW+1)'(hd) + (CW+1)'(ct);
    assign wpos = (wsum >= (CW+1)'(RING_DEPTH)) ? HW'(wsum - (CW+1)'(RING_DEPTH)) : HW'(wsum);
    assign hd_next = (hd == HW'(RING_DEPTH - 1)) ? '0 : hd + 1'b1;
    assign raddr = AW'(r_key * RING_DEPTH + hd);
    assign waddr = AW'(r_key * RING_DEPTH + wpos);
    assign we = (r_state == S_CHK) && (ct == '0 || live) && push && (ct != FULL);
    assign o_q_pop = (r_state == S_IDLE) && !o_valid;
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_out;

    swrl_ram #(.WIDTH(TIME_BITS), .DEPTH(KEYS * RING_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(r_time),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_time  <= '0;
            for (int i = 0; i < KEYS; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_it  <= i_q_item;
                        r_key <= key_slot(i_q_item.key_index);
                        r_state <= S_RD;
                        case (i_q_item.kind)
                            K_TICK: r_time <= r_time + 1'b1;
                            K_CLRKEY: begin
                                r_head[key_slot(i_q_item.key_index)] <= '0;
                                r_cnt[key_slot(i_q_item.key_index)]  <= '0;
                            end
                            K_CLRALL: begin
                                for (int i = 0; i < KEYS; i++) begin
                                    r_head[i] <= '0;
                                    r_cnt[i]  <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: r_state <= S_WAIT;
                S_WAIT: r_state <= S_CHK;
                S_CHK: begin
                    if (ct != '0 && !live) begin
                        // pop one expired stamp and read the next head
                        r_head[r_key] <= hd_next;
                        r_cnt[r_key]  <= ct - 1'b1;
                        r_state <= S_RD;
                    end else begin
                        if (push && ct != FULL) r_cnt[r_key] <= ct + 1'b1;
                        r_out.allowed   <= allowed;
                        r_out.count     <= 7'(ct + CW'(push && ct != FULL));
                        r_out.remaining <= allowed ? 7'(8'(r_it.limit) - 8'(ct)) : 7'd0;
                        r_out.wait_ticks <= (!allowed && ct != '0) ?
                            ((diff[16] || diff == '0) ? 16'd1 : diff[15:0]) : 16'd0;
                        r_out.overflow  <= push && (ct == FULL);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/swrl_checker.sv
// port level checks for the rate limiter
// depends on swrl_pkg; bound to sliding_window_rate_limiter
module swrl_port_checks
    import swrl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result dropped");
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.allowed |-> i_out_item.remaining == 7'd0)
        else $error("remaining");
    a_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.allowed |-> i_out_item.wait_ticks == 16'd0)
        else $error("retry");
endmodule

bind sliding_window_rate_limiter swrl_port_checks u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_out_valid(o_valid), .i_out_ready(i_ready),
    .i_out_item(o_item)
);
